// ----- sv/action_mask_to_hid_keyboard_report_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the keyboard report builder
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ACTION_MASK_TO_HID_KEYBOARD_REPORT_TOP_DEFINES_SVH
`define ACTION_MASK_TO_HID_KEYBOARD_REPORT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// prop is a full property expression (may use |-> or |=>)
`define AKR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// cond must never be true at a clock edge
`define AKR_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define AKR_ASSERT(lbl, prop, msg)
`define AKR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- sv/akr_pkg.sv -----
// ----------------------------------------------------------------------------
// akr_pkg
// Types and constants shared by the keyboard report builder.
// ----------------------------------------------------------------------------
`default_nettype none

package akr_pkg;

	localparam int USAGE_W     = 8;
	localparam int SLOT_FIELDS = 6;
	localparam int ACT_MAX     = 20;
	localparam int ACT_W       = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 56;

	typedef logic [USAGE_W-1:0] usage_t;
	typedef usage_t [SLOT_FIELDS-1:0] key_row_t;

	localparam usage_t USAGE_NONE   = 8'h00;
	localparam usage_t MOD_FIRST    = 8'hE0;
	localparam usage_t ERR_ROLLOVER = 8'h01;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_USAGE_LO  = 2'd0,
		REG_USAGE_MID = 2'd1,
		REG_USAGE_HI  = 2'd2
	} cfg_reg_t;

	// sequencer -> slot unit
	typedef struct packed {
		logic   clr;
		logic   en;
		usage_t usage;
	} slot_cmd_t;

	// slot unit -> top
	typedef struct packed {
		logic          rolled;
		logic [7:0]    mods;
		key_row_t      keys;
	} report_t;

endpackage

`default_nettype wire

// ----- sv/action_mask_to_hid_keyboard_report_top.sv -----
// ----------------------------------------------------------------------------
// action_mask_to_hid_keyboard_report_top
// Builds a 6-key boot keyboard report from a mask of active actions.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake            payload
//  s_axis    in    tvalid/tready        tdata[19:0] action mask
//  m_axis    out   tvalid/tready        tdata: modifiers, key slots 0..5
//                                       tuser[0] rollover_status
//  cfg       in    cfg_we (no wait)     cfg_index, cfg_data
//
//  An accepted item is scanned one action per cycle through the shared
//  slot unit, then the finished report is loaded into the output register.
//  s_axis_tready is high only while the sequencer is idle; the finished
//  report waits in the output register, so a new item may be scanned while
//  the previous report is stalled. The scan result is held until the output
//  register frees. arst_n clears the usage table to zero and empties the
//  output register.
//
// ----------------------------------------------------------------------------
`default_nettype none
`include "action_mask_to_hid_keyboard_report_top_defines.svh"

module action_mask_to_hid_keyboard_report_top import akr_pkg::*; #(
	parameter int NUM_ACTIONS = 20,
	parameter int KEY_SLOTS   = 6
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   s_axis_tvalid,
	output      logic                   s_axis_tready,
	// [19:0] action mask, [23:20] zero
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

	output      logic                   m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [7:0] modifier_bits, [15:8] key_slot_0 ... [55:48] key_slot_5
	output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] rollover_status
	output      logic                   m_axis_tuser,

	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [ACT_W-1:0]     act_q;
	logic [ACT_MAX-1:0]   mask_q;

	logic [63:0]          tbl_lo_q;
	logic [63:0]          tbl_mid_q;
	logic [31:0]          tbl_hi_q;

	logic                 out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                 out_roll_q;

	usage_t               usage_tbl [ACT_MAX];
	slot_cmd_t            cmd;
	report_t              rpt;
	logic                 in_fire;
	logic                 out_free;
	logic                 last_act;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_lo_q  <= '0;
			tbl_mid_q <= '0;
			tbl_hi_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_USAGE_LO:  tbl_lo_q  <= cfg_data;
				REG_USAGE_MID: tbl_mid_q <= cfg_data;
				REG_USAGE_HI:  tbl_hi_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// byte n of the packed registers is the usage of action n
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			usage_tbl[i]     = tbl_lo_q[8*i +: 8];
			usage_tbl[8 + i] = tbl_mid_q[8*i +: 8];
		end
		for (int i = 0; i < 4; i++) begin
			usage_tbl[16 + i] = tbl_hi_q[8*i +: 8];
		end
	end

	// ---------------- sequencer ----------------
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign last_act      = (act_q == ACT_W'(NUM_ACTIONS - 1));

	// actions at or above NUM_ACTIONS are never visited, so their mask bits drop out
	assign cmd.clr   = in_fire;
	assign cmd.en    = (state_q == ST_SCAN) && mask_q[act_q];
	assign cmd.usage = usage_tbl[act_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_roll_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						act_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_act) begin
						state_q <= ST_DONE;
					end else begin
						act_q <= act_q + ACT_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// output register: load the finished report, clear once taken
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				out_data_q  <= {rpt.keys, rpt.mods};
				out_roll_q  <= rpt.rolled;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// input payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mask_q <= s_axis_tdata[ACT_MAX-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_roll_q;

	// ---------------- shared slot unit ----------------
	akr_slot_unit #(
		.KEY_SLOTS (KEY_SLOTS)
	) u_slot (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rpt    (rpt)
	);

	`AKR_ASSERT(a_busy_after_accept, in_fire |=> !s_axis_tready, "ready right after accept")
	`AKR_ASSERT(a_roll_keys, (m_axis_tvalid && m_axis_tuser) |->
		(m_axis_tdata[15:8] == ERR_ROLLOVER), "rollover report without error code")
	`AKR_ASSERT(a_act_bound, (state_q == ST_SCAN) |-> (act_q < ACT_W'(NUM_ACTIONS)),
		"action counter past table")

endmodule

`default_nettype wire

// ----- sv/akr_slot_unit.sv -----
// ----------------------------------------------------------------------------
// akr_slot_unit
// Shared per-usage unit: modifier set, duplicate check, slot insert, rollover.
// ----------------------------------------------------------------------------
`default_nettype none
`include "action_mask_to_hid_keyboard_report_top_defines.svh"

module akr_slot_unit import akr_pkg::*; #(
	parameter int KEY_SLOTS = 6
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire slot_cmd_t cmd,
	output report_t        rpt
);

	localparam int FILL_W = $clog2(KEY_SLOTS + 1);

	usage_t            slot_q [KEY_SLOTS];
	logic [FILL_W-1:0] fill_q;
	logic              roll_q;
	logic [7:0]        mod_q;

	logic is_mod;
	logic is_none;
	logic hit;
	logic full;
	logic insert;

	assign is_none = (cmd.usage == USAGE_NONE);
	assign is_mod  = (cmd.usage[USAGE_W-1:3] == MOD_FIRST[USAGE_W-1:3]);
	assign full    = (fill_q == FILL_W'(KEY_SLOTS));

	// empty slots hold zero and a zero usage never reaches the key path
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (slot_q[i] == cmd.usage) begin
				hit = 1'b1;
			end
		end
	end

	assign insert = cmd.en && !is_none && !is_mod && !roll_q && !hit && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			roll_q <= 1'b0;
			mod_q  <= '0;
		end else if (cmd.clr) begin
			fill_q <= '0;
			roll_q <= 1'b0;
			mod_q  <= '0;
		end else if (cmd.en && !is_none) begin
			if (is_mod) begin
				mod_q <= mod_q | (8'h01 << cmd.usage[2:0]);
			end else if (!roll_q && !hit) begin
				if (full) begin
					roll_q <= 1'b1;
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (cmd.clr) begin
				slot_q[i] <= USAGE_NONE;
			end else if (insert && fill_q == FILL_W'(i)) begin
				slot_q[i] <= cmd.usage;
			end
		end
	end

	assign rpt.rolled = roll_q;
	assign rpt.mods   = mod_q;

	for (genvar g = 0; g < SLOT_FIELDS; g++) begin : g_key
		if (g < KEY_SLOTS) begin : g_used
			assign rpt.keys[g] = roll_q ? ERR_ROLLOVER : slot_q[g];
		end else begin : g_unused
			assign rpt.keys[g] = USAGE_NONE;
		end
	end

	`AKR_ASSERT_NEVER(a_fill_bound, fill_q > FILL_W'(KEY_SLOTS), "slot fill count overran")
	`AKR_ASSERT(a_roll_full, roll_q |-> full, "rollover with free key slots")
	`AKR_ASSERT(a_clr_empty, cmd.clr |=> (fill_q == '0 && !roll_q && mod_q == '0),
		"report state not cleared")

endmodule

`default_nettype wire

// ----- sim/tb_action_mask_to_hid_keyboard_report_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard report builder testbench
// Streams action masks through the block under several usage tables and
// stall patterns, and checks every report field against a local predictor.
// ----------------------------------------------------------------------------

module tb_action_mask_to_hid_keyboard_report_top;
	import akr_pkg::*;

	localparam int NUM_ACTIONS    = 20;
	localparam int KEY_SLOTS      = 6;
	localparam int LONG_HOLD      = 300;   // receiver hold-off, cycles
	localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer or register write
	localparam int TAIL_CYCLES    = 40;    // cycles, longer than one item's scan
	localparam int MAX_REPORTED   = 10;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 120;

	// no register lives at this index; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam usage_t MOD_LAST = MOD_FIRST + 8'd7;

	// table flavors for the random phases
	typedef enum int {
		TBL_ANY_BYTE,  // uniform bytes, any usage
		TBL_CROWDED,   // few keys, many dups and modifiers: rollover boundary
		TBL_ALL_ONES,  // every register all ones
		TBL_CLEARED    // every usage unmapped
	} table_style_t;

	// stall patterns
	typedef enum int {
		FLOW_FREE,
		FLOW_SENDER_GAPS,
		FLOW_RECEIVER_STALLS,
		FLOW_BOTH
	} flow_mode_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;

	// mirror of the usage table, one byte per action
	usage_t usage_lut [NUM_ACTIONS];

	logic [ACT_MAX-1:0] pending_masks[$];     // items not yet put on s_axis
	report_t            expected_reports[$];  // one per accepted item, in order

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asked = 0;   // bumped by the sequence to request a long hold-off
	int hold_taken = 0;
	int hold_left = 0;
	int mismatch_cnt = 0;
	int quiet_cycles = 0;
	report_t head_report;

	action_mask_to_hid_keyboard_report_top #(
		.NUM_ACTIONS (NUM_ACTIONS),
		.KEY_SLOTS   (KEY_SLOTS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Report predictor: scan actions low to high. Unmapped usages skip,
	// modifiers always land in the modifier byte (even once rolled over),
	// other usages take the next free slot unless already present. A key
	// that finds every slot taken flips the report into rollover.
	// ------------------------------------------------------------------
	function automatic report_t build_report(input logic [ACT_MAX-1:0] mask);
		report_t r;
		usage_t  u;
		int      filled;
		bit      seen;
		r = '0;
		filled = 0;
		for (int a = 0; a < NUM_ACTIONS; a++) begin
			if (!mask[a])
				continue;
			u = usage_lut[a];
			if (u == USAGE_NONE)
				continue;
			if (u >= MOD_FIRST && u <= MOD_LAST) begin
				r.mods[u[2:0]] = 1'b1;
				continue;
			end
			if (r.rolled)
				continue;
			seen = 1'b0;
			for (int s = 0; s < filled; s++)
				if (r.keys[s] == u)
					seen = 1'b1;
			if (seen)
				continue;
			if (filled >= KEY_SLOTS) begin
				r.rolled = 1'b1;
				continue;
			end
			r.keys[filled] = u;
			filled++;
		end
		if (r.rolled)
			for (int s = 0; s < KEY_SLOTS; s++)
				r.keys[s] = ERR_ROLLOVER;
		return r;
	endfunction

	// mix of sparse and dense masks so the key count straddles six
	function automatic logic [ACT_MAX-1:0] random_mask();
		logic [ACT_MAX-1:0] m;
		case ($urandom_range(3))
			0: m = ACT_MAX'($urandom & $urandom & $urandom);
			1: m = ACT_MAX'($urandom & $urandom);
			2: m = ACT_MAX'($urandom);
			default: m = ACT_MAX'($urandom | $urandom);
		endcase
		return m;
	endfunction

	function automatic usage_t pick_usage(input table_style_t style);
		usage_t u;
		case (style)
			TBL_ANY_BYTE: u = usage_t'($urandom_range(255));
			TBL_CROWDED: begin
				case ($urandom_range(3))
					0: u = USAGE_NONE;
					1: u = MOD_FIRST + usage_t'($urandom_range(7));
					default: u = 8'h04 + usage_t'($urandom_range(7));
				endcase
			end
			TBL_ALL_ONES: u = 8'hFF;
			default: u = USAGE_NONE;
		endcase
		return u;
	endfunction

	task automatic flag_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTED)
			$display("%0t mismatch on %s: expected %0h, got %0h", $realtime, field,
				want, got);
	endtask

	// one register write; the table mirror follows right away since writes
	// only happen while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_USAGE_LO:
				for (int b = 0; b < 8; b++)
					usage_lut[b] = value[8*b +: 8];
			REG_USAGE_MID:
				for (int b = 0; b < 8; b++)
					usage_lut[8+b] = value[8*b +: 8];
			REG_USAGE_HI:
				for (int b = 0; b < 4; b++)
					usage_lut[16+b] = value[8*b +: 8];
			default: ;
		endcase
	endtask

	task automatic load_table(input table_style_t style);
		logic [CFG_DATA_W-1:0] words [3];
		for (int r = 0; r < 3; r++)
			for (int b = 0; b < 8; b++)
				words[r][8*b +: 8] = pick_usage(style);
		// upper half of the hi word is outside the register and must vanish
		if (style == TBL_ALL_ONES)
			words[2][63:32] = '1;
		else
			words[2][63:32] = $urandom;
		write_reg(REG_USAGE_LO, words[0]);
		write_reg(REG_USAGE_MID, words[1]);
		write_reg(REG_USAGE_HI, words[2]);
		write_reg(REG_SPARE, {$urandom, $urandom});
	endtask

	// sender stays quiet until every report is back
	task automatic wait_drained();
		while (pending_masks.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_flow(input flow_mode_t mode);
		case (mode)
			FLOW_FREE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			FLOW_SENDER_GAPS: begin
				send_idle_pct = 50;
				recv_stall_pct = 0;
			end
			FLOW_RECEIVER_STALLS: begin
				send_idle_pct = 0;
				recv_stall_pct = 50;
			end
			default: begin
				send_idle_pct = 15;
				recv_stall_pct = 15;
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Sender: predicts each accepted item, then offers the next one.
	// tvalid only drops when there is nothing to send or a gap is rolled.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_reports.push_back(build_report(s_axis_tdata[ACT_MAX-1:0]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_masks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					// padding bits above the action mask stay zero
					s_axis_tdata  <= IN_TDATA_W'(pending_masks.pop_front());
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: checks each accepted report field by field against the
	// oldest prediction, then picks tready (random stall or long hold-off).
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_reports.size() == 0) begin
					flag_mismatch("report with none pending", '0, 64'(m_axis_tdata));
				end else begin
					head_report = expected_reports.pop_front();
					if (m_axis_tdata[7:0] !== head_report.mods)
						flag_mismatch("modifier_bits", 64'(head_report.mods),
							64'(m_axis_tdata[7:0]));
					for (int s = 0; s < SLOT_FIELDS; s++)
						if (m_axis_tdata[8+8*s +: 8] !== head_report.keys[s])
							flag_mismatch($sformatf("key_slot_%0d", s),
								64'(head_report.keys[s]), 64'(m_axis_tdata[8+8*s +: 8]));
					if (m_axis_tuser !== head_report.rolled)
						flag_mismatch("rollover_status", 64'(head_report.rolled),
							64'(m_axis_tuser));
				end
			end
			if (hold_taken != hold_asked) begin
				hold_taken    <= hold_asked;
				hold_left     <= LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left     <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog: any transfer or register write counts as progress
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	logic [ACT_MAX-1:0] directed_masks [15] = '{
		20'h00000,  // nothing active
		20'hFFFFF,  // everything active: rollover plus all modifiers
		20'h00001,  // single lowest action
		20'h80000,  // highest action, usage 0x01 taken as an ordinary key
		20'h0FF00,  // modifiers only
		20'h0003F,  // exactly six keys, no rollover
		20'h0007F,  // seventh distinct key rolls over
		20'h0807F,  // modifier seen after the rollover still counts
		20'h20001,  // same usage twice fills one slot
		20'h2003F,  // six keys and a duplicate: still fits
		20'h4003F,  // six keys and one more distinct: rollover
		20'h10000,  // mapped to nothing
		20'hAAAAA,
		20'h55555,
		20'h000FF   // eight keys
	};

	initial begin
		for (int a = 0; a < NUM_ACTIONS; a++)
			usage_lut[a] = USAGE_NONE;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset table: every usage unmapped, reports must be empty
		@(negedge clk);
		set_flow(FLOW_FREE);
		pending_masks.push_back(20'h00000);
		pending_masks.push_back(20'hFFFFF);
		wait_drained();

		// directed table: keys 0x04..0x0B on actions 0..7, every modifier
		// on 8..15, then unmapped, a duplicate 0x04, 0xFF and 0x01
		write_reg(REG_USAGE_LO, 64'h0B0A_0908_0706_0504);
		write_reg(REG_USAGE_MID, 64'hE7E6_E5E4_E3E2_E1E0);
		write_reg(REG_USAGE_HI, 64'hA5A5_5A5A_01FF_0400);
		write_reg(REG_SPARE, '1);
		@(negedge clk);
		foreach (directed_masks[i])
			pending_masks.push_back(directed_masks[i]);
		wait_drained();

		// random part: new table and stall pattern per phase; phase 4 runs
		// free on the sender side while the receiver holds off, so the block
		// backs up and drops s_axis_tready
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			load_table(table_style_t'((p / 4 + p) % 4));
			@(negedge clk);
			set_flow(flow_mode_t'(p % 4));
			if (p == 4)
				hold_asked++;
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_masks.push_back(random_mask());
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && expected_reports.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/akr_pkg.sv
sv/akr_slot_unit.sv
sv/action_mask_to_hid_keyboard_report_top.sv
sim/tb_action_mask_to_hid_keyboard_report_top.sv
